// ----- hdl/pfcw_pkg.sv -----
// ----------------------------------------------------------------------------
// pfcw_pkg
// Shared types, codes and constants of the per-flow congestion window unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfcw_pkg;

    localparam int FLOWS_DEF = 16;
    localparam int FRAC      = 16;
    localparam int TFRAC     = 10;

    localparam logic [31:0] WIN_ALL = 32'hFFFF_FFFF;
    localparam logic [31:0] WIN_ONE = 32'(64'(1) << FRAC);

    localparam int CBRT_SH = 3 * TFRAC - FRAC - 8;
    localparam int CBRT_SL = (CBRT_SH > 0) ? CBRT_SH : 0;
    localparam int CBRT_SR = (CBRT_SH < 0) ? -CBRT_SH : 0;
    localparam logic [4:0] CBRT_LAST_STEP = 5'd21;
    localparam int TERM_SH = 38 - FRAC;
    localparam logic [63:0] TERM_CAP  = 64'(1) << (62 - FRAC);
    localparam logic [63:0] RECIP_NUM = 64'(1) << (2 * FRAC);
    localparam logic [21:0] AD_CAP    = 22'h20_0000;

    localparam logic [31:0] US_PER_MS   = 32'd1000;
    // floor(2^41 / 1000), quotient is at most one low
    localparam logic [31:0] MS_RECIP    = 32'd2199023255;
    localparam int          MS_RECIP_SH = 41;
    // 2^TFRAC / 10^6 reduces to 2^4 / 15625
    localparam int          TG_SH       = TFRAC - 6;
    localparam logic [31:0] TG_DIV      = 32'd15625;
    // floor(2^45 / 15625), quotient is at most one low
    localparam logic [31:0] TG_RECIP    = 32'd2251799813;
    localparam int          TG_RECIP_SH = 45;

    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_INC    = 3'd1;
    localparam logic [2:0] CMD_TMO    = 3'd2;
    localparam logic [2:0] CMD_NACK   = 3'd3;
    localparam logic [2:0] CMD_LOCAL  = 3'd4;
    localparam logic [2:0] CMD_REMOTE = 3'd5;

    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_F_TIMEOUT  = 3'd1;
    localparam logic [2:0] CFG_F_LOCAL    = 3'd2;
    localparam logic [2:0] CFG_F_REMOTE   = 3'd3;
    localparam logic [2:0] CFG_CUBIC_DEC  = 3'd4;
    localparam logic [2:0] CFG_CUBIC_SC   = 3'd5;
    localparam logic [2:0] CFG_MIN_WIN    = 3'd6;
    localparam logic [2:0] CFG_INIT_WIN   = 3'd7;

    localparam logic ARITH_MUL = 1'b0;
    localparam logic ARITH_DIV = 1'b1;

    typedef logic [4:0] dp_op_t;

    localparam dp_op_t OP_NONE       = 5'd0;
    localparam dp_op_t OP_ACCEPT     = 5'd1;
    localparam dp_op_t OP_LOAD       = 5'd2;
    localparam dp_op_t OP_MUL_TIME   = 5'd3;
    localparam dp_op_t OP_SET_LAST   = 5'd4;
    localparam dp_op_t OP_INIT       = 5'd5;
    localparam dp_op_t OP_MUL_FACTOR = 5'd6;
    localparam dp_op_t OP_APPLY_DEC  = 5'd7;
    localparam dp_op_t OP_ADD_ONE    = 5'd8;
    localparam dp_op_t OP_SAT_ALL    = 5'd9;
    localparam dp_op_t OP_DIV_RECIP  = 5'd10;
    localparam dp_op_t OP_ADD_QUO    = 5'd11;
    localparam dp_op_t OP_SET_ERR    = 5'd12;
    localparam dp_op_t OP_MUL_PEAK   = 5'd13;
    localparam dp_op_t OP_DIV_K      = 5'd14;
    localparam dp_op_t OP_CBRT_INIT  = 5'd15;
    localparam dp_op_t OP_CBRT_A     = 5'd16;
    localparam dp_op_t OP_CBRT_B     = 5'd17;
    localparam dp_op_t OP_DUS        = 5'd18;
    localparam dp_op_t OP_MUL_TG     = 5'd19;
    localparam dp_op_t OP_SET_D      = 5'd20;
    localparam dp_op_t OP_MUL_SQ     = 5'd21;
    localparam dp_op_t OP_MUL_CUBE   = 5'd22;
    localparam dp_op_t OP_MUL_SCALE  = 5'd23;
    localparam dp_op_t OP_SET_TARGET = 5'd24;
    localparam dp_op_t OP_DIV_GROW   = 5'd25;
    localparam dp_op_t OP_WRITE      = 5'd26;
    localparam dp_op_t OP_FIX_LAST   = 5'd27;
    localparam dp_op_t OP_TG_REM     = 5'd28;
    localparam dp_op_t OP_TG_FIX     = 5'd29;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  flow_index;
        logic [39:0] time_us;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  flow_out;
        logic [31:0] window;
        logic [31:0] slow_start_threshold;
        logic        wmax_error;
    } out_beat_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic arith_done;
        logic is_init;
        logic is_dec;
        logic is_inc;
        logic inc_add_one;
        logic inc_recip;
        logic win_zero;
        logic peak_zero;
        logic cbrt_last;
        logic grow;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] a;
        logic [31:0] b;
    } arith_req_t;

    function automatic logic [31:0] packets_q(input logic [15:0] p);
        logic [63:0] v;
        v = 64'(p) << FRAC;
        return (v > 64'(WIN_ALL)) ? WIN_ALL : v[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pfcw_arith.sv -----
// ----------------------------------------------------------------------------
// pfcw_arith
// Shared multi-cycle unit: 64x32 multiply in two 32x32 halves, and
// 64/32 restoring divide at one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcw_arith import pfcw_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire arith_req_t  req,
    output logic             done,
    output logic [95:0]      result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        op_reg, op_next;
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [95:0] acc_reg, acc_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [63:0] part;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        part      = 64'(cnt_reg[0] ? a_reg[31:0] : a_reg[63:32]) * 64'(b_reg);
        shifted   = {rem_reg, a_reg[63]};
        diff      = {1'b0, shifted} - {2'b00, b_reg};
        ge        = !diff[33];
        if (req.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            op_next   = req.op;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = (req.op == ARITH_MUL) ? 6'd1 : 6'd63;
        end else if (busy_reg) begin
            if (op_reg == ARITH_MUL) begin
                // low half first, then high half
                if (cnt_reg[0]) begin
                    acc_next = acc_reg + 96'(part);
                end else begin
                    acc_next = acc_reg + (96'(part) << 32);
                end
            end else begin
                rem_next = ge ? diff[31:0] : shifted[31:0];
                a_next   = {a_reg[62:0], ge};
            end
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == ARITH_MUL) ? acc_reg : {32'd0, a_reg};

endmodule

`default_nettype wire

// ----- hdl/pfcw_dp.sv -----
// ----------------------------------------------------------------------------
// pfcw_dp
// Datapath: flow table memory, configuration registers, working registers,
// cube root steps and the output register; drives the shared arith unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcw_dp import pfcw_pkg::*; #(
    parameter int FLOWS = FLOWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    input  wire in_beat_t    s_data,
    output out_beat_t        m_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    typedef struct packed {
        logic [31:0] win;
        logic [31:0] thr;
        logic [31:0] peak;
        logic [30:0] last;
    } entry_t;

    entry_t mem [FLOWS];
    entry_t rd_reg;

    logic [1:0]  mode_reg;
    logic [15:0] f_tmo_reg, f_loc_reg, f_rem_reg, beta_reg, scale_reg;
    logic [15:0] min_win_reg, init_win_reg;

    logic [2:0]         cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [3:0]         fout_reg;
    logic [39:0]        now_reg;
    logic [31:0]        win_reg, thr_reg, peak_reg;
    logic [30:0]        last_reg;
    logic               err_reg;
    logic [63:0]        rem_reg;
    logic [21:0]        y_reg;
    logic [47:0]        b_reg;
    logic [4:0]         cnt_reg;
    logic signed [42:0] dus_reg;
    logic               d_neg_reg;
    logic [21:0]        ad_reg;
    logic signed [48:0] tgt_reg;
    logic [31:0]        tq_reg;
    logic [14:0]        tr_reg;
    out_beat_t          m_data_reg;
    logic               m_valid_reg, m_valid_next;

    arith_req_t  areq;
    logic        adone;
    logic [95:0] ares;

    logic [10:0]        wrap_v;
    logic [31:0]        floor_q;
    logic               cubic, lt;
    logic [31:0]        scaled;
    logic [15:0]        dec_factor;
    logic [42:0]        mag;
    logic [46:0]        tg_num, tg_rem;
    logic signed [39:0] tgs, dval;
    logic [39:0]        dmag;
    logic [63:0]        term;
    logic signed [48:0] inc;
    logic [64:0]        qsum;
    logic [21:0]        y2;
    logic [44:0]        yprod;
    logic [5:0]         sft;
    logic               hit;

    pfcw_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .done    (adone),
        .result  (ares)
    );

    // flow index wraps modulo the table depth
    always_comb begin
        wrap_v = 11'(s_data.flow_index);
        for (int i = 0; i < 8; i++) begin
            if (wrap_v >= 11'(FLOWS)) begin
                wrap_v = wrap_v - 11'(FLOWS);
            end
        end
    end

    always_comb begin
        floor_q    = packets_q(min_win_reg);
        cubic      = mode_reg[0];
        lt         = win_reg < thr_reg;
        scaled     = ares[47:16];
        dec_factor = beta_reg;
        if (cmd_reg == CMD_TMO || cmd_reg == CMD_NACK) begin
            dec_factor = f_tmo_reg;
        end else if (!cubic && cmd_reg == CMD_LOCAL) begin
            dec_factor = f_loc_reg;
        end else if (!cubic) begin
            dec_factor = f_rem_reg;
        end
        mag    = dus_reg[42] ? 43'(-dus_reg) : 43'(dus_reg);
        tg_num = 47'(mag) << TG_SH;
        tg_rem = tg_num - 47'(ares[TG_RECIP_SH +: 32]) * 47'(TG_DIV);
        tgs  = dus_reg[42] ? -$signed(40'(tq_reg)) : $signed(40'(tq_reg));
        dval = tgs - $signed(40'(y_reg));
        dmag = dval[39] ? 40'(-dval) : 40'(dval);
        term = (|ares[95:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : ares[63:0];
        term = term >> TERM_SH;
        if (term > TERM_CAP) begin
            term = TERM_CAP;
        end
        inc   = tgt_reg - $signed({17'd0, win_reg});
        qsum  = {33'd0, win_reg} + {1'b0, ares[63:0]};
        y2    = {y_reg[20:0], 1'b0};
        yprod = 45'(y2) * 45'(y2 + 22'd1);
        sft   = {1'b0, cnt_reg} + {cnt_reg, 1'b0};
        hit   = (rem_reg >> sft) >= 64'(b_reg);
    end

    always_comb begin
        areq.start = 1'b0;
        areq.op    = ARITH_MUL;
        areq.a     = '0;
        areq.b     = '0;
        case (cmd.op)
            OP_MUL_TIME: begin
                areq = '{1'b1, ARITH_MUL, 64'(now_reg), MS_RECIP};
            end
            OP_MUL_FACTOR: begin
                areq = '{1'b1, ARITH_MUL, 64'(win_reg), 32'(dec_factor)};
            end
            OP_DIV_RECIP: begin
                areq = '{1'b1, ARITH_DIV, RECIP_NUM, win_reg};
            end
            OP_MUL_PEAK: begin
                areq = '{1'b1, ARITH_MUL, 64'(peak_reg), 32'(17'h1_0000 - 17'(beta_reg))};
            end
            OP_DIV_K: begin
                areq = '{1'b1, ARITH_DIV, ares[63:0],
                         (scale_reg == 16'd0) ? 32'd1 : 32'(scale_reg)};
            end
            OP_MUL_TG: begin
                areq = '{1'b1, ARITH_MUL, 64'(tg_num), TG_RECIP};
            end
            OP_MUL_SQ: begin
                areq = '{1'b1, ARITH_MUL, 64'(ad_reg), 32'(ad_reg)};
            end
            OP_MUL_CUBE: begin
                areq = '{1'b1, ARITH_MUL, ares[63:0], 32'(ad_reg)};
            end
            OP_MUL_SCALE: begin
                areq = '{1'b1, ARITH_MUL, ares[63:0], 32'(scale_reg)};
            end
            OP_DIV_GROW: begin
                areq = '{1'b1, ARITH_DIV, {15'd0, inc} << FRAC, win_reg};
            end
            default: begin
                areq.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 2'd0;
            f_tmo_reg    <= 16'd32768;
            f_loc_reg    <= 16'd32768;
            f_rem_reg    <= 16'd32768;
            beta_reg     <= 16'd45875;
            scale_reg    <= 16'd102;
            min_win_reg  <= 16'd1;
            init_win_reg <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:      mode_reg     <= cfg_wdata[1:0];
                CFG_F_TIMEOUT: f_tmo_reg    <= cfg_wdata;
                CFG_F_LOCAL:   f_loc_reg    <= cfg_wdata;
                CFG_F_REMOTE:  f_rem_reg    <= cfg_wdata;
                CFG_CUBIC_DEC: beta_reg     <= cfg_wdata;
                CFG_CUBIC_SC:  scale_reg    <= cfg_wdata;
                CFG_MIN_WIN:   min_win_reg  <= cfg_wdata;
                CFG_INIT_WIN:  init_win_reg <= cfg_wdata;
            endcase
        end
    end

    // table memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_ACCEPT) begin
            rd_reg <= mem[wrap_v[IDX_W-1:0]];
        end
        if (cmd.op == OP_WRITE) begin
            mem[idx_reg] <= '{win_reg, thr_reg, peak_reg, last_reg};
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                cmd_reg  <= s_data.cmd;
                idx_reg  <= wrap_v[IDX_W-1:0];
                fout_reg <= wrap_v[3:0];
                now_reg  <= s_data.time_us;
            end
            OP_LOAD: begin
                win_reg  <= rd_reg.win;
                thr_reg  <= rd_reg.thr;
                peak_reg <= rd_reg.peak;
                last_reg <= rd_reg.last;
                err_reg  <= 1'b0;
            end
            OP_SET_LAST: begin
                last_reg <= ares[MS_RECIP_SH +: 31];
                dus_reg  <= $signed(43'(now_reg))
                            - $signed(43'(ares[MS_RECIP_SH +: 31]) * 43'(US_PER_MS));
            end
            OP_FIX_LAST: begin
                if (dus_reg >= $signed(43'(US_PER_MS))) begin
                    last_reg <= last_reg + 31'd1;
                end
            end
            OP_INIT: begin
                win_reg  <= packets_q(init_win_reg);
                thr_reg  <= WIN_ALL;
                peak_reg <= packets_q(init_win_reg);
            end
            OP_APPLY_DEC: begin
                if (cubic && cmd_reg == CMD_REMOTE) begin
                    win_reg <= (win_reg < floor_q) ? floor_q : win_reg;
                end else begin
                    if (cubic && cmd_reg == CMD_LOCAL) begin
                        peak_reg <= win_reg;
                        thr_reg  <= (scaled < floor_q) ? floor_q : scaled;
                    end else begin
                        thr_reg <= scaled;
                    end
                    win_reg <= (scaled < floor_q) ? floor_q : scaled;
                end
            end
            OP_ADD_ONE: begin
                win_reg <= ({1'b0, win_reg} + {1'b0, WIN_ONE} > {1'b0, WIN_ALL}) ? WIN_ALL
                           : win_reg + WIN_ONE;
            end
            OP_SAT_ALL: win_reg <= WIN_ALL;
            OP_ADD_QUO: win_reg <= (qsum > 65'(WIN_ALL)) ? WIN_ALL : qsum[31:0];
            OP_SET_ERR: err_reg <= 1'b1;
            OP_CBRT_INIT: begin
                rem_reg <= (ares[63:0] << CBRT_SL) >> CBRT_SR;
                y_reg   <= '0;
                cnt_reg <= CBRT_LAST_STEP;
            end
            OP_CBRT_A: begin
                y_reg <= y2;
                b_reg <= 48'(yprod) * 48'd3 + 48'd1;
            end
            OP_CBRT_B: begin
                if (hit) begin
                    rem_reg <= rem_reg - (64'(b_reg) << sft);
                    y_reg   <= y_reg + 22'd1;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            OP_DUS: begin
                dus_reg <= $signed(43'(now_reg)) - $signed(43'(last_reg) * 43'(US_PER_MS));
            end
            OP_TG_REM: begin
                tq_reg <= ares[TG_RECIP_SH +: 32];
                tr_reg <= tg_rem[14:0];
            end
            OP_TG_FIX: begin
                if (tr_reg >= 15'(TG_DIV)) begin
                    tq_reg <= tq_reg + 32'd1;
                end
            end
            OP_SET_D: begin
                d_neg_reg <= dval[39];
                ad_reg    <= (dmag > 40'(AD_CAP)) ? AD_CAP : dmag[21:0];
            end
            OP_SET_TARGET: begin
                tgt_reg <= d_neg_reg ? $signed({17'd0, peak_reg}) - $signed({2'b00, term[46:0]})
                                     : $signed({17'd0, peak_reg}) + $signed({2'b00, term[46:0]});
            end
            OP_WRITE: begin
                m_data_reg <= '{fout_reg, win_reg, thr_reg, err_reg};
            end
            default: begin
                err_reg <= err_reg;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.op == OP_WRITE) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        status.arith_done  = adone;
        status.is_init     = cmd_reg == CMD_INIT;
        status.is_dec      = cmd_reg == CMD_TMO || cmd_reg == CMD_NACK
                             || cmd_reg == CMD_LOCAL || cmd_reg == CMD_REMOTE;
        status.is_inc      = cmd_reg == CMD_INC;
        status.inc_add_one = !(cubic && !lt) && (cubic || !mode_reg[1] || lt);
        status.inc_recip   = !cubic && mode_reg[1] && !lt;
        status.win_zero    = win_reg == 32'd0;
        status.peak_zero   = peak_reg == 32'd0;
        status.cbrt_last   = cnt_reg == 5'd0;
        status.grow        = tgt_reg > $signed({17'd0, win_reg});
        status.out_free    = !m_valid_reg || m_ready;
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/pfcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfcw_ctrl
// Controller: sequences one beat through load, arithmetic steps and
// write back, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfcw_ctrl import pfcw_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire dp_status_t  status,
    output dp_cmd_t          cmd
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_LOAD       = 5'd1;
    localparam logic [4:0] S_DECIDE     = 5'd2;
    localparam logic [4:0] S_WAIT_TIME  = 5'd3;
    localparam logic [4:0] S_AFTER_TIME = 5'd4;
    localparam logic [4:0] S_WAIT_DEC   = 5'd5;
    localparam logic [4:0] S_WAIT_RECIP = 5'd6;
    localparam logic [4:0] S_WAIT_PEAK  = 5'd7;
    localparam logic [4:0] S_WAIT_K     = 5'd8;
    localparam logic [4:0] S_CBRT_A     = 5'd9;
    localparam logic [4:0] S_CBRT_B     = 5'd10;
    localparam logic [4:0] S_DUS        = 5'd11;
    localparam logic [4:0] S_MUL_TG     = 5'd12;
    localparam logic [4:0] S_WAIT_TG    = 5'd13;
    localparam logic [4:0] S_SQ         = 5'd14;
    localparam logic [4:0] S_WAIT_SQ    = 5'd15;
    localparam logic [4:0] S_WAIT_CUBE  = 5'd16;
    localparam logic [4:0] S_WAIT_SCALE = 5'd17;
    localparam logic [4:0] S_GROW       = 5'd18;
    localparam logic [4:0] S_WRITE      = 5'd19;
    localparam logic [4:0] S_FIX_LAST   = 5'd20;
    localparam logic [4:0] S_TG_FIX     = 5'd21;
    localparam logic [4:0] S_SET_D      = 5'd22;

    logic [4:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.op     = OP_LOAD;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (status.is_init || status.is_dec) begin
                    cmd.op     = OP_MUL_TIME;
                    state_next = S_WAIT_TIME;
                end else if (!status.is_inc) begin
                    state_next = S_WRITE;
                end else if (status.inc_add_one) begin
                    cmd.op     = OP_ADD_ONE;
                    state_next = S_WRITE;
                end else if (status.inc_recip) begin
                    if (status.win_zero) begin
                        cmd.op     = OP_SAT_ALL;
                        state_next = S_WRITE;
                    end else begin
                        cmd.op     = OP_DIV_RECIP;
                        state_next = S_WAIT_RECIP;
                    end
                end else if (status.peak_zero) begin
                    cmd.op     = OP_SET_ERR;
                    state_next = S_WRITE;
                end else begin
                    cmd.op     = OP_MUL_PEAK;
                    state_next = S_WAIT_PEAK;
                end
            end
            S_WAIT_TIME: begin
                if (status.arith_done) begin
                    cmd.op     = OP_SET_LAST;
                    state_next = S_FIX_LAST;
                end
            end
            S_FIX_LAST: begin
                cmd.op     = OP_FIX_LAST;
                state_next = S_AFTER_TIME;
            end
            S_AFTER_TIME: begin
                if (status.is_init) begin
                    cmd.op     = OP_INIT;
                    state_next = S_WRITE;
                end else begin
                    cmd.op     = OP_MUL_FACTOR;
                    state_next = S_WAIT_DEC;
                end
            end
            S_WAIT_DEC: begin
                if (status.arith_done) begin
                    cmd.op     = OP_APPLY_DEC;
                    state_next = S_WRITE;
                end
            end
            S_WAIT_RECIP: begin
                if (status.arith_done) begin
                    cmd.op     = OP_ADD_QUO;
                    state_next = S_WRITE;
                end
            end
            S_WAIT_PEAK: begin
                if (status.arith_done) begin
                    cmd.op     = OP_DIV_K;
                    state_next = S_WAIT_K;
                end
            end
            S_WAIT_K: begin
                if (status.arith_done) begin
                    cmd.op     = OP_CBRT_INIT;
                    state_next = S_CBRT_A;
                end
            end
            S_CBRT_A: begin
                cmd.op     = OP_CBRT_A;
                state_next = S_CBRT_B;
            end
            S_CBRT_B: begin
                cmd.op     = OP_CBRT_B;
                state_next = status.cbrt_last ? S_DUS : S_CBRT_A;
            end
            S_DUS: begin
                cmd.op     = OP_DUS;
                state_next = S_MUL_TG;
            end
            S_MUL_TG: begin
                cmd.op     = OP_MUL_TG;
                state_next = S_WAIT_TG;
            end
            S_WAIT_TG: begin
                if (status.arith_done) begin
                    cmd.op     = OP_TG_REM;
                    state_next = S_TG_FIX;
                end
            end
            S_TG_FIX: begin
                cmd.op     = OP_TG_FIX;
                state_next = S_SET_D;
            end
            S_SET_D: begin
                cmd.op     = OP_SET_D;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op     = OP_MUL_SQ;
                state_next = S_WAIT_SQ;
            end
            S_WAIT_SQ: begin
                if (status.arith_done) begin
                    cmd.op     = OP_MUL_CUBE;
                    state_next = S_WAIT_CUBE;
                end
            end
            S_WAIT_CUBE: begin
                if (status.arith_done) begin
                    cmd.op     = OP_MUL_SCALE;
                    state_next = S_WAIT_SCALE;
                end
            end
            S_WAIT_SCALE: begin
                if (status.arith_done) begin
                    cmd.op     = OP_SET_TARGET;
                    state_next = S_GROW;
                end
            end
            S_GROW: begin
                if (!status.grow) begin
                    state_next = S_WRITE;
                end else if (status.win_zero) begin
                    cmd.op     = OP_SAT_ALL;
                    state_next = S_WRITE;
                end else begin
                    cmd.op     = OP_DIV_GROW;
                    state_next = S_WAIT_RECIP;
                end
            end
            S_WRITE: begin
                if (status.out_free) begin
                    cmd.op     = OP_WRITE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/per_flow_congestion_window.sv -----
// ----------------------------------------------------------------------------
// per_flow_congestion_window
// Increase by one and unknown commands go straight to write back; init and
// decreases add a time multiply (decreases also a factor multiply); a reciprocal
// increase a divide, a CUBIC increase up to two divides and the cube root steps;
// output stalls hold write back. Throughput: one beat at a time, no overlap.
// Reset: control and configuration return to defaults; flow table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_flow_congestion_window import pfcw_pkg::*; #(
    parameter int FLOWS = FLOWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    pfcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    pfcw_dp #(
        .FLOWS (FLOWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

`default_nettype wire

// ----- tb/sv/per_flow_congestion_window_tb.sv -----
// ----------------------------------------------------------------------------
// per_flow_congestion_window_tb
// Drives flow commands into the congestion window unit in AIMD, slow-start
// and CUBIC modes, predicts every window, threshold and error flag from a
// local copy of the flow table, and checks each output beat in order under
// random gaps and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_flow_congestion_window_tb;
    import pfcw_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int RANDOM_BEATS    = 1900;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    per_flow_congestion_window dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow configuration and flow table
    logic [1:0]  mode_q = 2'd0;
    logic [15:0] f_tmo_q = 16'd32768, f_loc_q = 16'd32768, f_rem_q = 16'd32768;
    logic [15:0] beta_q = 16'd45875, scale_q = 16'd102, min_win_q = 16'd1, init_win_q = 16'd1;
    logic [31:0] win_tab [16];
    logic [31:0] thr_tab [16];
    logic [31:0] peak_tab [16];
    logic [30:0] last_ms_tab [16];
    logic [15:0] flow_live = '0;

    out_beat_t   pending_updates [$];
    int          errors = 0;
    int          beats_sent = 0;
    int          beats_checked = 0;
    int          cubic_beats = 0;
    int          err_flags_seen = 0;
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [39:0] clock_us = '0;

    function automatic logic [31:0] sat_win(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? WIN_ALL : v[31:0];
    endfunction

    function automatic logic [31:0] whole_to_q(logic [15:0] p);
        return sat_win(64'(p) << FRAC);
    endfunction

    function automatic logic [31:0] mul_frac(logic [31:0] w, logic [15:0] f);
        return 32'((64'(w) * 64'(f)) >> 16);
    endfunction

    function automatic longint unsigned int_cube_root(longint unsigned x);
        longint unsigned y, b;
        y = 0;
        for (int s = 63; s >= 0; s -= 3) begin
            y = y << 1;
            b = 64'd3 * y * (y + 64'd1) + 64'd1;
            if ((x >> s) >= b) begin
                x = x - (b << s);
                y = y + 64'd1;
            end
        end
        return y;
    endfunction

    function automatic logic [31:0] cubic_window(logic [31:0] win, logic [31:0] peak,
                                                 logic [39:0] now, logic [30:0] last);
        longint unsigned c, x, kc, mag, ad, d3, term, grow;
        longint k, dus, tg, d, target;
        c = (scale_q == 0) ? 64'd1 : 64'(scale_q);
        x = (64'(peak) * (64'd65536 - 64'(beta_q))) / c;
        kc = (x << CBRT_SL) >> CBRT_SR;
        k = longint'(int_cube_root(kc));
        dus = longint'(64'(now)) - longint'(64'(last)) * 64'sd1000;
        mag = (dus < 0) ? longint'(-dus) : longint'(dus);
        tg = longint'((mag << TFRAC) / 64'd1000000);
        if (dus < 0) tg = -tg;
        d = tg - k;
        ad = (d < 0) ? longint'(-d) : longint'(d);
        if (ad > 64'(AD_CAP)) ad = 64'(AD_CAP);
        d3 = ad * ad * ad;
        if (d3 != 0 && 64'(scale_q) > 64'hFFFF_FFFF_FFFF_FFFF / d3) term = '1;
        else term = d3 * 64'(scale_q);
        term = term >> TERM_SH;
        if (term > TERM_CAP) term = TERM_CAP;
        target = (d < 0) ? longint'(64'(peak)) - longint'(term)
                         : longint'(64'(peak)) + longint'(term);
        if (target <= longint'(64'(win))) return win;
        grow = 64'(target - longint'(64'(win)));
        if (win == 0) return WIN_ALL;
        return sat_win(64'(win) + (grow << FRAC) / 64'(win));
    endfunction

    function automatic out_beat_t update_flow(in_beat_t b);
        out_beat_t r;
        logic [3:0]  f;
        logic [31:0] win, thr, peak, floor_q;
        logic        cubic, err;
        f = b.flow_index;
        win = win_tab[f];
        thr = thr_tab[f];
        peak = peak_tab[f];
        cubic = mode_q[0];
        err = 1'b0;
        if (b.cmd == CMD_INIT) begin
            win = whole_to_q(init_win_q);
            thr = WIN_ALL;
            peak = win;
            last_ms_tab[f] = 31'(b.time_us / 40'd1000);
        end else if (b.cmd == CMD_INC) begin
            if (cubic || !mode_q[1] || win < thr) begin
                if (cubic && win >= thr) begin
                    if (peak == 0) err = 1'b1;
                    else win = cubic_window(win, peak, b.time_us, last_ms_tab[f]);
                end else begin
                    win = sat_win(64'(win) + 64'(WIN_ONE));
                end
            end else begin
                win = (win == 0) ? WIN_ALL : sat_win(64'(win) + RECIP_NUM / 64'(win));
            end
        end else if (b.cmd <= CMD_REMOTE) begin
            floor_q = whole_to_q(min_win_q);
            last_ms_tab[f] = 31'(b.time_us / 40'd1000);
            if (b.cmd == CMD_TMO || b.cmd == CMD_NACK) begin
                thr = mul_frac(win, f_tmo_q);
                win = thr;
            end else if (!cubic) begin
                thr = mul_frac(win, (b.cmd == CMD_LOCAL) ? f_loc_q : f_rem_q);
                win = thr;
            end else if (b.cmd == CMD_LOCAL) begin
                peak = win;
                thr = mul_frac(win, beta_q);
                if (thr < floor_q) thr = floor_q;
                win = mul_frac(win, beta_q);
            end
            if (win < floor_q) win = floor_q;
        end
        win_tab[f] = win;
        thr_tab[f] = thr;
        peak_tab[f] = peak;
        r.flow_out = f;
        r.window = win;
        r.slow_start_threshold = thr;
        r.wmax_error = err;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(logic [2:0] cmd, logic [3:0] flow, logic [39:0] t);
        in_beat_t b;
        int gap;
        b.cmd = cmd;
        b.flow_index = flow;
        b.time_us = t;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_INIT) flow_live[flow] = 1'b1;
        if (mode_q[0]) cubic_beats++;
        pending_updates.push_back(update_flow(b));
        beats_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODE:      mode_q = val[1:0];
            CFG_F_TIMEOUT: f_tmo_q = val;
            CFG_F_LOCAL:   f_loc_q = val;
            CFG_F_REMOTE:  f_rem_q = val;
            CFG_CUBIC_DEC: beta_q = val;
            CFG_CUBIC_SC:  scale_q = val;
            CFG_MIN_WIN:   min_win_q = val;
            default:       init_win_q = val;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomize_regs();
        write_reg(CFG_MODE, 16'($urandom));
        write_reg(CFG_F_TIMEOUT, pick_reg_value());
        write_reg(CFG_F_LOCAL, pick_reg_value());
        write_reg(CFG_F_REMOTE, pick_reg_value());
        write_reg(CFG_CUBIC_DEC, pick_reg_value());
        write_reg(CFG_CUBIC_SC, pick_reg_value());
        write_reg(CFG_MIN_WIN, 16'($urandom_range(0, 8)));
        write_reg(CFG_INIT_WIN, ($urandom_range(0, 9) == 0) ? pick_reg_value()
                                                             : 16'($urandom_range(1, 64)));
    endtask

    function automatic logic [39:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return {8'($urandom), 32'($urandom)};
        if (r < 8) return clock_us - 40'($urandom_range(0, 3000000));
        clock_us = clock_us + 40'($urandom_range(0, 400000));
        return clock_us;
    endfunction

    // output checker
    always @(posedge aclk) begin
        out_beat_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, m_data);
                errors++;
            end else begin
                exp_b = pending_updates.pop_front();
                beats_checked++;
                if (m_data.wmax_error) err_flags_seen++;
                if (m_data.flow_out !== exp_b.flow_out) begin
                    $display("%0t: flow_out exp %0d got %0d", $time,
                             exp_b.flow_out, m_data.flow_out);
                    errors++;
                end
                if (m_data.window !== exp_b.window) begin
                    $display("%0t: window exp %h got %h", $time, exp_b.window, m_data.window);
                    errors++;
                end
                if (m_data.slow_start_threshold !== exp_b.slow_start_threshold) begin
                    $display("%0t: threshold exp %h got %h", $time,
                             exp_b.slow_start_threshold, m_data.slow_start_threshold);
                    errors++;
                end
                if (m_data.wmax_error !== exp_b.wmax_error) begin
                    $display("%0t: wmax_error exp %b got %b", $time,
                             exp_b.wmax_error, m_data.wmax_error);
                    errors++;
                end
            end
        end
    end

    // receiver ready with random stalls and a long hold on request
    always @(negedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 600;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_aimd_commands();
        send_beat(CMD_INIT, 4'd0, 40'd0);
        send_beat(CMD_INC, 4'd0, 40'd10);
        send_beat(CMD_INC, 4'd0, 40'd20);
        send_beat(CMD_TMO, 4'd0, 40'd1500);
        send_beat(CMD_NACK, 4'd0, 40'd2500);
        send_beat(CMD_LOCAL, 4'd0, 40'd3500);
        send_beat(CMD_REMOTE, 4'd0, 40'd4500);
        send_beat(3'd6, 4'd0, 40'd5000);
        send_beat(3'd7, 4'd0, 40'hFF_FFFF_FFFF);
        send_beat(CMD_INIT, 4'd15, 40'hFF_FFFF_FFFF);
        drain();
        write_reg(CFG_MODE, 16'd2);
        send_beat(CMD_INC, 4'd0, 40'd6000);
        send_beat(CMD_INC, 4'd15, 40'd6000);
        drain();
    endtask

    task automatic test_cubic_growth();
        write_reg(CFG_MODE, 16'd1);
        send_beat(CMD_INIT, 4'd1, 40'd1000);
        send_beat(CMD_LOCAL, 4'd1, 40'd2000000);
        send_beat(CMD_INC, 4'd1, 40'd3000000);
        send_beat(CMD_INC, 4'd1, 40'd1500000);
        send_beat(CMD_REMOTE, 4'd1, 40'd4000000);
        send_beat(CMD_INC, 4'd1, 40'hFF_FFFF_FFFF);
        drain();
        write_reg(CFG_CUBIC_SC, 16'd0);
        send_beat(CMD_INC, 4'd1, 40'd9000000);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(CFG_INIT_WIN, 16'hFFFF);
        write_reg(CFG_MIN_WIN, 16'hFFFF);
        send_beat(CMD_INIT, 4'd2, 40'd0);
        send_beat(CMD_INC, 4'd2, 40'd1);
        send_beat(CMD_TMO, 4'd2, 40'd2);
        drain();
        write_reg(CFG_INIT_WIN, 16'd0);
        write_reg(CFG_MIN_WIN, 16'd0);
        write_reg(CFG_F_TIMEOUT, 16'd0);
        send_beat(CMD_INIT, 4'd3, 40'd0);
        send_beat(CMD_TMO, 4'd3, 40'd100);
        send_beat(CMD_INC, 4'd3, 40'd200);
        drain();
        write_reg(CFG_MODE, 16'd2);
        send_beat(CMD_INC, 4'd3, 40'd300);
        drain();
    endtask

    task automatic random_phase(int count);
        logic [3:0] f;
        logic [2:0] c;
        int r;
        for (int i = 0; i < count; i++) begin
            f = 4'($urandom);
            r = $urandom_range(0, 99);
            if (r < 50) c = CMD_INC;
            else if (r < 58) c = CMD_INIT;
            else if (r < 66) c = CMD_TMO;
            else if (r < 73) c = CMD_NACK;
            else if (r < 84) c = CMD_LOCAL;
            else if (r < 95) c = CMD_REMOTE;
            else c = 3'($urandom_range(6, 7));
            if (!flow_live[f]) c = CMD_INIT;
            send_beat(c, f, next_time());
        end
        drain();
    endtask

    task automatic test_random_traffic();
        int done_beats;
        done_beats = 0;
        for (int f = 0; f < 16; f++) begin
            send_beat(CMD_INIT, 4'(f), clock_us);
        end
        drain();
        while (done_beats < RANDOM_BEATS) begin
            randomize_regs();
            no_idle = ($urandom_range(0, 4) == 0);
            random_phase(150);
            done_beats += 150;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MODE, 16'd1);
        write_reg(CFG_INIT_WIN, 16'd10);
        write_reg(CFG_MIN_WIN, 16'd1);
        @(negedge aclk);
        hold_request = 1'b1;
        no_idle = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_beat((i % 3 == 0) ? CMD_LOCAL : CMD_INC, 4'(i), next_time());
        end
        no_idle = 1'b0;
        drain();
        // sender stays quiet until everything has come back, then resumes
        send_beat(CMD_INC, 4'd4, next_time());
        send_beat(CMD_INC, 4'd5, next_time());
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_aimd_commands();
        test_cubic_growth();
        test_extremes();
        test_random_traffic();
        test_backpressure();
        repeat (300) @(posedge aclk);
        if (pending_updates.size() != 0) begin
            $display("%0t: %0d updates never arrived", $time, pending_updates.size());
            errors++;
        end
        $display("sent %0d beats, checked %0d, %0d in cubic mode, %0d error flags",
                 beats_sent, beats_checked, cubic_beats, err_flags_seen);
        $display("covered aimd, slow start, cubic, saturation, zero windows, long stall");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
